@@ hdl/gdd_pkg.sv @@
// Shared types, constants and helpers of the Golomb delta decoder.
package gdd_pkg;

	localparam int SYM_W     = 16;
	localparam int DIV_W     = 9;
	localparam int QUOT_W    = 8;
	localparam int REM_W     = 8;
	localparam int RLEN_W    = 4;
	localparam int VALUE_W   = QUOT_W + DIV_W;
	localparam int DELTA_W   = VALUE_W + 1;
	localparam int TOTAL_W   = 32;
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

	localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(4);
	localparam logic [DIV_W-1:0]  DIV_MAX    = DIV_W'(256);
	localparam logic [QUOT_W-1:0] QUOT_SAT   = {QUOT_W{1'b1}};

	// One update of the running total, handed from the front to the back.
	typedef struct packed {
		logic               from_escape;
		logic [DELTA_W-1:0] delta;
	} op_t;

	// Zero acts as one, anything above the largest divisor is clamped.
	function automatic logic [DIV_W-1:0] eff_divisor(input logic [DIV_W-1:0] raw);
		logic [DIV_W-1:0] d;
		d = raw;
		if (d == '0)
			d = DIV_W'(1);
		if (d > DIV_MAX)
			d = DIV_MAX;
		return d;
	endfunction

	// Remainder field length: ceiling of log2 of the divisor (divisor is 1..256).
	function automatic logic [RLEN_W-1:0] rem_len(input logic [DIV_W-1:0] d);
		logic [RLEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < REM_W; i++) begin
			if (d > (DIV_W'(1) << i))
				n = n + RLEN_W'(1);
		end
		return n;
	endfunction

endpackage

@@ hdl/golomb_delta_decoder_top.sv @@
// Top level of the Golomb delta decoder with escape values and a running total.
//
//  channel   direction  handshake                 word
//  -------   ---------  ------------------------  ---------------------------------
//  input     in         push / full               symbol[15:0], signed
//  result    out        pop / empty               running_total[31:0], from_escape
//  config    in         cfg_valid / cfg_ready     cfg_data[8:0], the divisor
//
// One symbol is taken every cycle while full is low. With the result side free, an
// update written into the four-entry update queue is loaded into the result register
// at the next edge, so a result word passes through the update queue and the result
// register before it is on the ports; the sustained rate is one symbol per cycle.
// The front end settles a codeword value with one 8x9 multiply in the accepting
// cycle; the back end does one 32-bit add per cycle. cfg_ready is always high.
// Reset clears the codeword state, the total, the update queue and the result
// register, and loads divisor 4. A stalled result stops the back end only; the front
// end keeps going until the update queue fills.
module golomb_delta_decoder_top
	import gdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [SYM_W-1:0]   symbol,
	output logic               empty,
	input  logic               pop,
	output logic [TOTAL_W-1:0] running_total,
	output logic               from_escape,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [DIV_W-1:0]   cfg_data
);

	logic opq_full;
	logic opq_empty;
	logic op_push;
	logic opq_rd;
	op_t  op_in;
	op_t  op_out;

	assign cfg_ready = 1'b1;
	assign full      = opq_full;

	// Classifies each symbol and turns finished codewords and escapes into updates.
	gdd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.symbol   (symbol),
		.opq_full (opq_full),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.op_push  (op_push),
		.op       (op_in)
	);

	// Decouples the two halves so a slow result consumer does not stall input at once.
	gdd_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (op_push),
		.wr_op  (op_in),
		.rd     (opq_rd),
		.rd_op  (op_out),
		.full   (opq_full),
		.empty  (opq_empty)
	);

	// Keeps the running total and presents one result word at a time.
	gdd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.opq_empty     (opq_empty),
		.opq_op        (op_out),
		.opq_rd        (opq_rd),
		.pop           (pop),
		.empty         (empty),
		.running_total (running_total),
		.from_escape   (from_escape)
	);

endmodule

@@ hdl/gdd_front.sv @@
// Front end: takes stream symbols, tracks the codeword and issues total updates.
module gdd_front
	import gdd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [SYM_W-1:0] symbol,
	input  logic             opq_full,
	input  logic             cfg_we,
	input  logic [DIV_W-1:0] cfg_data,
	output logic             op_push,
	output op_t              op
);

	logic              sign_taken_q;
	logic              sign_bit_q;
	logic              in_rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [RLEN_W-1:0] rem_seen_q;
	logic [REM_W-1:0]  rem_q;
	logic [DIV_W-1:0]  div_q;
	logic [RLEN_W-1:0] rlen_q;

	logic              accept;
	logic              escape;
	logic              bit_in;
	logic              finish;
	logic [REM_W-1:0]  rem_next;
	logic [RLEN_W-1:0] seen_next;
	logic [REM_W-1:0]  rem_used;
	logic [VALUE_W-1:0] value;
	logic [DELTA_W-1:0] mag;

	assign accept    = push && !opq_full;
	assign escape    = (symbol[SYM_W-1:1] != '0);
	assign bit_in    = symbol[0];
	assign rem_next  = {rem_q[REM_W-2:0], bit_in};
	assign seen_next = rem_seen_q + RLEN_W'(1);

	always_comb begin
		finish   = 1'b0;
		rem_used = rem_q;
		if (!escape && sign_taken_q) begin
			if (!in_rem_q) begin
				finish = bit_in && (rlen_q == '0);
			end else begin
				finish   = (seen_next >= rlen_q);
				rem_used = rem_next;
			end
		end
	end

	assign value = VALUE_W'(quot_q) * VALUE_W'(div_q) + VALUE_W'(rem_used);
	assign mag   = {1'b0, value};

	always_comb begin
		op.from_escape = escape;
		if (escape)
			op.delta = {{(DELTA_W-SYM_W){symbol[SYM_W-1]}}, symbol};
		else if (sign_bit_q)
			op.delta = -mag;
		else
			op.delta = mag;
	end

	assign op_push = accept && (escape || finish);

	// The effective divisor and the field length are settled when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= DIV_RESET;
			rlen_q <= rem_len(DIV_RESET);
		end else if (cfg_we) begin
			div_q  <= eff_divisor(cfg_data);
			rlen_q <= rem_len(eff_divisor(cfg_data));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_taken_q <= 1'b0;
			sign_bit_q   <= 1'b0;
			in_rem_q     <= 1'b0;
			quot_q       <= '0;
			rem_seen_q   <= '0;
			rem_q        <= '0;
		end else if (accept && !escape) begin
			if (finish) begin
				sign_taken_q <= 1'b0;
				sign_bit_q   <= 1'b0;
				in_rem_q     <= 1'b0;
				quot_q       <= '0;
				rem_seen_q   <= '0;
				rem_q        <= '0;
			end else if (!sign_taken_q) begin
				sign_bit_q   <= bit_in;
				sign_taken_q <= 1'b1;
			end else if (!in_rem_q) begin
				if (!bit_in) begin
					if (quot_q != QUOT_SAT)
						quot_q <= quot_q + QUOT_W'(1);
				end else begin
					in_rem_q   <= 1'b1;
					rem_seen_q <= '0;
					rem_q      <= '0;
				end
			end else begin
				rem_q      <= rem_next;
				rem_seen_q <= seen_next;
			end
		end
	end

	a_rem_needs_sign: assert property (@(posedge clk) disable iff (!arst_n)
		in_rem_q |-> sign_taken_q)
		else $error("remainder phase entered without a sign bit");

	a_quot_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !escape && sign_taken_q && !in_rem_q && !bit_in && quot_q == QUOT_SAT
		|=> quot_q == QUOT_SAT)
		else $error("quotient count wrapped past saturation");

endmodule

@@ hdl/gdd_opq.sv @@
// Short queue of total updates between the front and the back.
module gdd_opq
	import gdd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  op_t  wr_op,
	input  logic rd,
	output op_t  rd_op,
	output logic full,
	output logic empty
);

	op_t               mem_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wptr_q;
	logic [OPQ_AW-1:0] rptr_q;
	logic [OPQ_CW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full  = (count_q == OPQ_CW'(OPQ_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_op = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= wptr_q + OPQ_AW'(1);
			if (do_rd)
				rptr_q <= rptr_q + OPQ_AW'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + OPQ_CW'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - OPQ_CW'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OPQ_CW'(OPQ_DEPTH))
		else $error("update queue count beyond its depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + OPQ_CW'(1))
		else $error("update queue lost a word");

endmodule

@@ hdl/gdd_back.sv @@
// Back end: applies updates to the running total and holds the result word.
module gdd_back
	import gdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               opq_empty,
	input  op_t                opq_op,
	output logic               opq_rd,
	input  logic               pop,
	output logic               empty,
	output logic [TOTAL_W-1:0] running_total,
	output logic               from_escape
);

	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic               out_esc_q;

	assign opq_rd = !opq_empty && (!out_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_esc_q   <= 1'b0;
		end else if (opq_rd) begin
			total_q     <= total_q + {{(TOTAL_W-DELTA_W){opq_op.delta[DELTA_W-1]}},
				opq_op.delta};
			out_esc_q   <= opq_op.from_escape;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// The total only moves when a new result is loaded, so it is the result.
	assign running_total = total_q;
	assign from_escape   = out_esc_q;
	assign empty         = !out_valid_q;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(total_q) && $stable(out_esc_q))
		else $error("waiting result changed before it was taken");

endmodule

@@ sim/tb_golomb_delta_decoder_top.sv @@
// Self-checking testbench for the Golomb delta decoder top level.
module tb_golomb_delta_decoder_top;
	import gdd_pkg::*;

	// Worst quiet stretch of a correct run is a sender gap, a receiver stall and the
	// pipe through the update queue and result register. The limit is far above that.
	localparam int QUIET_LIMIT  = 1000;
	// Cycles allowed after the last expected word before the block counts as idle.
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 90;

	// One expected result word: the running total and where it came from.
	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               esc;
	} total_word_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [SYM_W-1:0]   symbol;
	logic               empty;
	logic               pop;
	logic [TOTAL_W-1:0] running_total;
	logic               from_escape;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [DIV_W-1:0]   cfg_data;

	golomb_delta_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.symbol        (symbol),
		.empty         (empty),
		.pop           (pop),
		.running_total (running_total),
		.from_escape   (from_escape),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Decoder state as the testbench sees it. It is only written by the monitor,
	// which updates it at every accepting clock edge.
	logic [DIV_W-1:0]   div_reg     = 9'd4;
	logic               have_sign   = 1'b0;
	logic               neg_code    = 1'b0;
	logic               in_rem      = 1'b0;
	logic [7:0]         quot        = '0;
	logic [3:0]         rem_seen    = '0;
	logic [7:0]         rem_acc     = '0;
	logic [TOTAL_W-1:0] total_acc   = '0;
	total_word_t        pending_totals[$];

	int  mismatch_count = 0;
	int  items_sent     = 0;
	int  quiet_cycles   = 0;
	bit  send_idle      = 1'b0;
	bit  pop_idle       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Divisor as the decoder uses it: zero acts as one, values above 256 clamp.
	function automatic int used_divisor(input logic [DIV_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (raw > 9'd256)
			return 256;
		return int'(raw);
	endfunction

	// Remainder field length: smallest n with 2**n at or above the divisor.
	function automatic int rem_bits(input logic [DIV_W-1:0] raw);
		int d;
		int n;
		d = used_divisor(raw);
		n = 0;
		while ((1 << n) < d)
			n++;
		return n;
	endfunction

	function automatic int idle_cycles(input bit on);
		return on ? $urandom_range(9, 0) : 0;
	endfunction

	// Escapes lean on the field extremes now and then; 0 and 1 are code bits.
	function automatic logic [SYM_W-1:0] escape_value();
		int v;
		case ($urandom_range(7, 0))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'hFFFF;
			3: v = 16'h0002;
			default: begin
				v = $urandom_range(65535, 0);
				if (v < 2)
					v = v + 2;
			end
		endcase
		return v[SYM_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		if (mismatch_count < 40)
			$display("mismatch at %0t: %s got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Adds a finished codeword to the total and queues the word it produces.
	task automatic close_codeword();
		logic [31:0] value;
		value = 32'(quot) * 32'(used_divisor(div_reg)) + 32'(rem_acc);
		total_acc = neg_code ? total_acc - value : total_acc + value;
		pending_totals.push_back('{total: total_acc, esc: 1'b0});
		have_sign = 1'b0;
		neg_code  = 1'b0;
		in_rem    = 1'b0;
		quot      = '0;
		rem_seen  = '0;
		rem_acc   = '0;
	endtask

	// Works out what one accepted symbol does to the decoder state.
	task automatic decode_symbol(input logic [SYM_W-1:0] s);
		int rlen;
		rlen = rem_bits(div_reg);
		if (s != 16'd0 && s != 16'd1) begin
			// An escape never touches a codeword that is partly read.
			total_acc = total_acc + {{(TOTAL_W-SYM_W){s[SYM_W-1]}}, s};
			pending_totals.push_back('{total: total_acc, esc: 1'b1});
		end else if (!have_sign) begin
			neg_code  = s[0];
			have_sign = 1'b1;
		end else if (!in_rem) begin
			if (!s[0]) begin
				// The quotient sticks at its top value; more zeros change nothing.
				if (quot != 8'hFF)
					quot = quot + 8'd1;
			end else if (rlen == 0) begin
				close_codeword();
			end else begin
				in_rem   = 1'b1;
				rem_seen = '0;
				rem_acc  = '0;
			end
		end else begin
			rem_acc  = {rem_acc[6:0], s[0]};
			rem_seen = rem_seen + 4'd1;
			if (int'(rem_seen) >= rlen)
				close_codeword();
		end
	endtask

	// Monitor: checks each popped word against the oldest expectation, then follows
	// register writes and accepted symbols. Everything is sampled at the rising edge,
	// where the inputs have been stable since the falling edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		total_word_t want;
		if (!arst_n) begin
			div_reg   = 9'd4;
			have_sign = 1'b0;
			neg_code  = 1'b0;
			in_rem    = 1'b0;
			quot      = '0;
			rem_seen  = '0;
			rem_acc   = '0;
			total_acc = '0;
			pending_totals.delete();
		end else begin
			if (pop && !empty) begin
				if (pending_totals.size() == 0) begin
					report_mismatch("word with nothing pending", running_total, '0);
				end else begin
					want = pending_totals.pop_front();
					if (running_total !== want.total)
						report_mismatch("running_total", running_total, want.total);
					if (from_escape !== want.esc)
						report_mismatch("from_escape", 32'(from_escape), 32'(want.esc));
				end
			end
			if (cfg_valid && cfg_ready)
				div_reg = cfg_data;
			if (push && !full)
				decode_symbol(symbol);
		end
	end

	// Watchdog: counts cycles in which no word moves on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[golomb_delta_decoder_top] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Result side: before each word it may hold pop low for a drawn number of cycles,
	// then keeps pop high until a word is taken.
	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		forever begin
			gap = idle_cycles(pop_idle);
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	end

	// Sends one symbol after a drawn gap and returns at the edge that takes it. Push
	// is left high so back-to-back symbols need no second assignment in one step.
	task automatic send_symbol(input logic [SYM_W-1:0] s);
		int gap;
		gap = idle_cycles(send_idle);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push   <= 1'b1;
		symbol <= s;
		do
			@(posedge clk);
		while (full);
		items_sent++;
	endtask

	task automatic send_bits(input string bits);
		for (int i = 0; i < bits.len(); i++)
			send_symbol(bits[i] == "1" ? 16'd1 : 16'd0);
	endtask

	// Lowers push, waits until every expected word is out, then lets the pipe settle.
	// A trailing code bit gives no word, so the extra cycles cover it.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic set_divisor(input logic [DIV_W-1:0] d);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A code bit, sometimes preceded by an escape that lands inside the codeword.
	task automatic send_code_bit(input bit b);
		if ($urandom_range(11, 0) == 0)
			send_symbol(escape_value());
		send_symbol({15'b0, b});
	endtask

	task automatic send_codeword(input int quot_len);
		int rlen;
		rlen = rem_bits(div_reg);
		send_code_bit(1'($urandom_range(1, 0)));
		for (int i = 0; i < quot_len; i++)
			send_code_bit(1'b0);
		send_code_bit(1'b1);
		for (int i = 0; i < rlen; i++)
			send_code_bit(1'($urandom_range(1, 0)));
	endtask

	// Both sign extremes and every symbol bit in both states; the total ends at zero.
	task automatic test_escape_extremes();
		send_symbol(16'h7FFF);
		send_symbol(16'h8000);
		send_symbol(16'hFFFF);
		send_symbol(16'h0002);
	endtask

	// Sign and one quotient zero, then an escape, then the rest of the codeword:
	// the escape word comes first and the codeword still adds 1*4+1.
	task automatic test_escape_mid_codeword();
		send_bits("00");
		send_symbol(16'h0005);
		send_bits("101");
	endtask

	// Divisor one has no remainder bits, so the terminating one closes the codeword.
	// This subtracts one from the total.
	task automatic test_divisor_one();
		set_divisor(9'd1);
		send_bits("101");
	endtask

	// Divisor zero must behave like divisor one.
	task automatic test_divisor_zero();
		set_divisor(9'd0);
		send_bits("01");
	endtask

	// With divisor three the remainder field is two bits and may read 3, which is
	// used as is.
	task automatic test_divisor_three();
		set_divisor(9'd3);
		send_bits("0111");
	endtask

	// All-ones divisor clamps to 256: eight remainder bits, here subtracting 255.
	task automatic test_divisor_clamp();
		set_divisor(9'h1FF);
		send_bits("1111111111");
	endtask

	// A quotient run well past 255 zeros at the largest divisor; the count sticks.
	task automatic test_quotient_saturation();
		set_divisor(9'd256);
		send_idle = 1'b1;
		pop_idle  = 1'b1;
		send_codeword(262);
		send_idle = 1'b0;
		pop_idle  = 1'b0;
	endtask

	// Random streams over a sweep of divisors, each phase with one of four idling patterns.
	// Most items are whole codewords with random content and stray escapes; the rest
	// are lone escapes and lone code bits, which break the codeword framing.
	task automatic test_random_streams();
		logic [DIV_W-1:0] divs[17];
		int start;
		int pick;
		divs = '{9'd4, 9'd1, 9'd0, 9'd2, 9'd3, 9'd5, 9'd8, 9'd9, 9'd100, 9'd127,
		         9'd128, 9'd129, 9'd255, 9'd256, 9'd257, 9'h1FF, 9'd0};
		divs[16] = DIV_W'($urandom_range(511, 0));
		for (int k = 0; k < 17; k++) begin
			set_divisor(divs[k]);
			send_idle = k[0];
			pop_idle  = k[1];
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				pick = $urandom_range(9, 0);
				if (pick < 7)
					send_codeword($urandom_range(7, 0) == 0 ?
					              $urandom_range(20, 4) : $urandom_range(3, 0));
				else if (pick == 7)
					send_symbol(escape_value());
				else
					send_symbol({15'b0, 1'($urandom_range(1, 0))});
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		symbol    = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_escape_extremes();
		test_escape_mid_codeword();
		test_divisor_one();
		test_divisor_zero();
		test_divisor_three();
		test_divisor_clamp();
		test_quotient_saturation();
		test_random_streams();

		settle();
		if (mismatch_count == 0)
			$display("[golomb_delta_decoder_top] OK");
		else
			$display("[golomb_delta_decoder_top] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/gdd_pkg.sv
hdl/gdd_front.sv
hdl/gdd_opq.sv
hdl/gdd_back.sv
hdl/golomb_delta_decoder_top.sv
sim/tb_golomb_delta_decoder_top.sv
